>>> rtl/tfpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfpc_pkg
// Shared types, widths and codes for the triangle face and plane cull core.
// ----------------------------------------------------------------------------
package tfpc_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int NLO_W = 34;
  localparam int NHI_W = CROSS_W - NLO_W;
  localparam int PLO_W = DIFF_W + NLO_W + 1;
  localparam int PHI_W = DIFF_W + NHI_W;
  localparam int LOSUM_W = PLO_W + 2;
  localparam int HISUM_W = PHI_W + 2;
  localparam int DOT_W = HISUM_W + NLO_W + 2;
  localparam int NUM_STAGES = 6;
  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MODE_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EYE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CULL_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_B = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_C = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_D = 3'd7;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BACK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FRONT = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] third_x;
    logic signed [COORD_W-1:0] third_y;
    logic signed [COORD_W-1:0] third_z;
  } tri_t;

  typedef struct packed {
    logic       face_culled;
    logic [2:0] outside_mask;
    logic       plane_culled;
    logic       fully_outside;
  } res_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/tfpc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfpc_if
// Valid/ready channels for triangle items and cull result items.
// ----------------------------------------------------------------------------
interface tfpc_tri_if;
  logic          valid;
  logic          ready;
  tfpc_pkg::tri_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tfpc_res_if;
  logic          valid;
  logic          ready;
  tfpc_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/tfpc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfpc_ctrl
// Stage valid bits and per-stage load enables for the cull pipeline.
// ----------------------------------------------------------------------------
module tfpc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tfpc_pkg::pipe_ctrl_t      ctrl
);
  import tfpc_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] valid_next;
  logic [NUM_STAGES:0]   adv;

  always_comb begin
    adv[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  always_comb begin
    valid_next = valid;
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        valid_next[k] = (k == 0) ? in_valid : valid[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign ctrl.en   = adv[NUM_STAGES-1:0];
  assign in_ready  = adv[0];
  assign out_valid = valid[NUM_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/tfpc_face.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfpc_face
// Facing test: edge vectors, cross product, split dot product with the eye
// vector, sign decision against the cull mode. Six register stages.
// ----------------------------------------------------------------------------
module tfpc_face (
  input  wire logic                                  clk,
  input  wire tfpc_pkg::pipe_ctrl_t                  ctrl,
  input  wire tfpc_pkg::tri_t                        tri_data,
  input  wire logic signed [tfpc_pkg::COORD_W-1:0]   eye_x,
  input  wire logic signed [tfpc_pkg::COORD_W-1:0]   eye_y,
  input  wire logic signed [tfpc_pkg::COORD_W-1:0]   eye_z,
  input  wire logic [tfpc_pkg::MODE_W-1:0]           cull_mode,
  output logic                                       face_culled
);
  import tfpc_pkg::*;

  // stage 1: differences
  logic signed [DIFF_W-1:0] ux, uy, uz, vx, vy, vz, ex1, ey1, ez1;
  // stage 2: cross product terms
  logic signed [PROD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [DIFF_W-1:0] ex2, ey2, ez2;
  // stage 3: normal
  logic signed [CROSS_W-1:0] nx, ny, nz;
  logic signed [DIFF_W-1:0]  ex3, ey3, ez3;
  // stage 4: partial products
  logic signed [NLO_W:0]    nlo_x, nlo_y, nlo_z;
  logic signed [NHI_W-1:0]  nhi_x, nhi_y, nhi_z;
  logic signed [PLO_W-1:0]  plo_x, plo_y, plo_z;
  logic signed [PHI_W-1:0]  phi_x, phi_y, phi_z;
  // stage 5: partial sums
  logic signed [LOSUM_W-1:0] losum;
  logic signed [HISUM_W-1:0] hisum;
  // stage 6: decision
  logic signed [DOT_W-1:0]   dot;
  logic                      dot_neg;
  logic                      dot_zero;
  logic                      face_next;

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      ux  <= DIFF_W'(tri_data.second_x) - DIFF_W'(tri_data.first_x);
      uy  <= DIFF_W'(tri_data.second_y) - DIFF_W'(tri_data.first_y);
      uz  <= DIFF_W'(tri_data.second_z) - DIFF_W'(tri_data.first_z);
      vx  <= DIFF_W'(tri_data.third_x) - DIFF_W'(tri_data.first_x);
      vy  <= DIFF_W'(tri_data.third_y) - DIFF_W'(tri_data.first_y);
      vz  <= DIFF_W'(tri_data.third_z) - DIFF_W'(tri_data.first_z);
      ex1 <= DIFF_W'(eye_x) - DIFF_W'(tri_data.first_x);
      ey1 <= DIFF_W'(eye_y) - DIFF_W'(tri_data.first_y);
      ez1 <= DIFF_W'(eye_z) - DIFF_W'(tri_data.first_z);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      p_yz <= uy * vz;
      p_zy <= uz * vy;
      p_zx <= uz * vx;
      p_xz <= ux * vz;
      p_xy <= ux * vy;
      p_yx <= uy * vx;
      ex2  <= ex1;
      ey2  <= ey1;
      ez2  <= ez1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      nx  <= CROSS_W'(p_yz) - CROSS_W'(p_zy);
      ny  <= CROSS_W'(p_zx) - CROSS_W'(p_xz);
      nz  <= CROSS_W'(p_xy) - CROSS_W'(p_yx);
      ex3 <= ex2;
      ey3 <= ey2;
      ez3 <= ez2;
    end
  end

  // split each normal component into an unsigned low part and a signed high part
  assign nlo_x = $signed({1'b0, nx[NLO_W-1:0]});
  assign nlo_y = $signed({1'b0, ny[NLO_W-1:0]});
  assign nlo_z = $signed({1'b0, nz[NLO_W-1:0]});
  assign nhi_x = nx[CROSS_W-1:NLO_W];
  assign nhi_y = ny[CROSS_W-1:NLO_W];
  assign nhi_z = nz[CROSS_W-1:NLO_W];

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      plo_x <= ex3 * nlo_x;
      plo_y <= ey3 * nlo_y;
      plo_z <= ez3 * nlo_z;
      phi_x <= ex3 * nhi_x;
      phi_y <= ey3 * nhi_y;
      phi_z <= ez3 * nhi_z;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      losum <= LOSUM_W'(plo_x) + LOSUM_W'(plo_y) + LOSUM_W'(plo_z);
      hisum <= HISUM_W'(phi_x) + HISUM_W'(phi_y) + HISUM_W'(phi_z);
    end
  end

  always_comb begin
    dot      = (DOT_W'(hisum) <<< NLO_W) + DOT_W'(losum);
    dot_neg  = dot[DOT_W-1];
    dot_zero = (dot == '0);
    unique case (cull_mode)
      MODE_BACK:  face_next = dot_neg || dot_zero;
      MODE_FRONT: face_next = !dot_neg;
      MODE_NONE:  face_next = 1'b0;
      default:    face_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      face_culled <= face_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tfpc_plane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfpc_plane
// Clip plane test of the three vertices: products, exact sum, sign, then
// delay of the outside mask to line up with the facing result.
// ----------------------------------------------------------------------------
module tfpc_plane #(
  parameter int FRAC_BITS = tfpc_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire tfpc_pkg::pipe_ctrl_t                  ctrl,
  input  wire tfpc_pkg::tri_t                        tri_data,
  input  wire logic signed [tfpc_pkg::COORD_W-1:0]   plane_a,
  input  wire logic signed [tfpc_pkg::COORD_W-1:0]   plane_b,
  input  wire logic signed [tfpc_pkg::COORD_W-1:0]   plane_c,
  input  wire logic signed [tfpc_pkg::COORD_W-1:0]   plane_d,
  output logic [2:0]                                 outside_mask
);
  import tfpc_pkg::*;

  localparam int MUL_W = 2 * COORD_W;
  localparam int OFS_W = COORD_W + FRAC_BITS;
  localparam int SUM_W = ((MUL_W > OFS_W) ? MUL_W : OFS_W) + 2;

  logic signed [COORD_W-1:0] px [3];
  logic signed [COORD_W-1:0] py [3];
  logic signed [COORD_W-1:0] pz [3];
  logic signed [MUL_W-1:0]   ax [3];
  logic signed [MUL_W-1:0]   by [3];
  logic signed [MUL_W-1:0]   cz [3];
  logic signed [SUM_W-1:0]   ofs;
  logic signed [SUM_W-1:0]   plane_sum [3];
  logic [2:0]                mask_next;
  logic [2:0]                mask_pipe [1:NUM_STAGES-1];

  assign px[0] = tri_data.first_x;
  assign py[0] = tri_data.first_y;
  assign pz[0] = tri_data.first_z;
  assign px[1] = tri_data.second_x;
  assign py[1] = tri_data.second_y;
  assign pz[1] = tri_data.second_z;
  assign px[2] = tri_data.third_x;
  assign py[2] = tri_data.third_y;
  assign pz[2] = tri_data.third_z;

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      for (int k = 0; k < 3; k++) begin
        ax[k] <= plane_a * px[k];
        by[k] <= plane_b * py[k];
        cz[k] <= plane_c * pz[k];
      end
    end
  end

  assign ofs = SUM_W'(plane_d) <<< FRAC_BITS;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      plane_sum[k] = SUM_W'(ax[k]) + SUM_W'(by[k]) + SUM_W'(cz[k]) + ofs;
      mask_next[k] = plane_sum[k][SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      mask_pipe[1] <= mask_next;
    end
    for (int s = 2; s < NUM_STAGES; s++) begin
      if (ctrl.en[s]) begin
        mask_pipe[s] <= mask_pipe[s-1];
      end
    end
  end

  assign outside_mask = mask_pipe[NUM_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/triangle_face_and_plane_cull_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_face_and_plane_cull_core
// Back/front face cull and single clip plane test of one triangle per item.
// ----------------------------------------------------------------------------
// Input channel tri_in carries one triangle (three Q16.16 vertices) per item;
// output channel res_out carries one cull result item per triangle, in order.
// Both use valid/ready; an item moves on a clock edge where both are high.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) that
// sets the eye position, the cull mode and the plane; write it only while no
// triangle is in flight.
// One triangle is accepted every cycle while res_out is ready or a stage is
// empty. The depth is set by the split 33x67 dot product multiply, which
// takes a partial product stage and two summing stages after the cross
// product.
// When res_out stalls, every stage that holds an item holds it and tri_in
// keeps accepting until the empty stages in front are filled.
// Synchronous reset empties the pipeline and loads the register defaults:
// eye and plane all zero, cull mode back.
// ----------------------------------------------------------------------------
module triangle_face_and_plane_cull_core #(
  parameter int FRAC_BITS = tfpc_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  tfpc_tri_if.sink                                tri_in,
  tfpc_res_if.source                              res_out,
  input  wire logic                               cfg_we,
  input  wire logic [tfpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tfpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tfpc_pkg::*;

  logic signed [COORD_W-1:0] eye_x, eye_y, eye_z;
  logic signed [COORD_W-1:0] plane_a, plane_b, plane_c, plane_d;
  logic [MODE_W-1:0]         cull_mode;
  pipe_ctrl_t                ctrl;
  logic                      face_culled;
  logic [2:0]                outside_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x     <= '0;
      eye_y     <= '0;
      eye_z     <= '0;
      cull_mode <= MODE_BACK;
      plane_a   <= '0;
      plane_b   <= '0;
      plane_c   <= '0;
      plane_d   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EYE_X:     eye_x     <= cfg_wdata;
        REG_EYE_Y:     eye_y     <= cfg_wdata;
        REG_EYE_Z:     eye_z     <= cfg_wdata;
        REG_CULL_MODE: cull_mode <= cfg_wdata[MODE_W-1:0];
        REG_PLANE_A:   plane_a   <= cfg_wdata;
        REG_PLANE_B:   plane_b   <= cfg_wdata;
        REG_PLANE_C:   plane_c   <= cfg_wdata;
        REG_PLANE_D:   plane_d   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tfpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tri_in.valid),
    .in_ready  (tri_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .ctrl      (ctrl)
  );

  tfpc_face u_face (
    .clk         (clk),
    .ctrl        (ctrl),
    .tri_data    (tri_in.data),
    .eye_x       (eye_x),
    .eye_y       (eye_y),
    .eye_z       (eye_z),
    .cull_mode   (cull_mode),
    .face_culled (face_culled)
  );

  tfpc_plane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_plane (
    .clk          (clk),
    .ctrl         (ctrl),
    .tri_data     (tri_in.data),
    .plane_a      (plane_a),
    .plane_b      (plane_b),
    .plane_c      (plane_c),
    .plane_d      (plane_d),
    .outside_mask (outside_mask)
  );

  assign res_out.data.face_culled   = face_culled;
  assign res_out.data.outside_mask  = outside_mask;
  assign res_out.data.plane_culled  = !face_culled && (|outside_mask);
  assign res_out.data.fully_outside = !face_culled && (&outside_mask);

endmodule
`default_nettype wire
